// ===== hdl/ipt_pkg.sv =====
// ----------------------------------------------------------------------------
// ipt_pkg: shared types and constants for the interval phase timer
// Payload structs, command codes, phase and run-state codes, and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ipt_pkg;

  // Transition queue geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Short breaks before a long break
  localparam logic [1:0] SESS_MAX = 2'd3;

  // Divide by 1000 through a reciprocal: q = (x * DIV_MUL) >> DIV_SHIFT
  localparam int          MS_PER_SEC = 1000;
  localparam int          DIV_SHIFT  = 38;
  localparam logic [28:0] DIV_MUL    = 29'd274877907;
  localparam int          PROD_W     = 61;
  localparam int          QUO_W      = PROD_W - DIV_SHIFT;

  // Register reset values
  localparam logic [31:0] WORK_RST  = 32'd1500000;
  localparam logic [31:0] SHORT_RST = 32'd300000;
  localparam logic [31:0] LONG_RST  = 32'd900000;

  // Configuration register indexes
  localparam logic [1:0] CFG_WORK  = 2'd0;
  localparam logic [1:0] CFG_SHORT = 2'd1;
  localparam logic [1:0] CFG_LONG  = 2'd2;

  // Command codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_RESUME = 3'd3;
  localparam logic [2:0] OP_TOGGLE = 3'd4;
  localparam logic [2:0] OP_RESET  = 3'd5;
  localparam logic [2:0] OP_SKIP   = 3'd6;
  localparam logic [2:0] OP_DRAIN  = 3'd7;

  // Phase codes
  localparam logic [1:0] PH_WORK  = 2'd0;
  localparam logic [1:0] PH_SHORT = 2'd1;
  localparam logic [1:0] PH_LONG  = 2'd2;

  // Run-state codes
  localparam logic [1:0] RS_IDLE  = 2'd0;
  localparam logic [1:0] RS_RUN   = 2'd1;
  localparam logic [1:0] RS_PAUSE = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] elapsed_ms;
    logic [7:0]  take_limit;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  run_state;
    logic [31:0] remaining_ms;
    logic [31:0] duration_ms;
    logic [1:0]  sessions_done;
    logic [31:0] change_count;
    logic [31:0] transition_count;
    logic [3:0]  pending;
    logic        transition_valid;
    logic [1:0]  from_phase;
    logic [1:0]  to_phase;
    logic        last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // latch the accepted input transaction
    logic apply;        // execute a non-tick, non-drain command
    logic tick_finish;  // tick covers the remaining time: end the phase
    logic rem_calc;     // form the sub-second remainder from the product
    logic tick_sub;     // tick stays inside the phase: subtract
    logic drain_start;  // take the drain count off the queue fill
    logic pop;          // emit one drained transition
    logic emit;         // emit the single result of the command
  } ipt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       running;
    logic       e_zero;
    logic       tl_gt_e;
    logic       drain_none;
    logic       cnt_last;
    logic       out_free;
  } ipt_sts_t;

endpackage

`default_nettype wire

// ===== hdl/ipt_datapath.sv =====
// ----------------------------------------------------------------------------
// ipt_datapath: timer state, transition queue and output register
// Holds phase lengths, run state, counters and the circular transition
// queue; carries out the steps that the controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_datapath import ipt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ipt_cmd_t    cmd_i,
  output ipt_sts_t         sts_o,
  input  wire in_item_t    in_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output out_item_t        out_data_o
);

  // Configuration registers
  logic [31:0] work_q, short_q, long_q;
  logic [31:0] cfg_val;

  // Timer state
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  mode_q, mode_d;
  logic [31:0] tl_q, tl_d;
  logic [31:0] len_q, len_d;
  logic [1:0]  sess_q, sess_d;
  logic [31:0] gen_q, gen_d;
  logic [31:0] trc_q, trc_d;

  // Transition queue
  logic [3:0]        queue_q [QUEUE_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W:0]    wr_sum;
  logic [PTR_W-1:0]  wr_addr;
  logic              rec;
  logic [3:0]        entry;

  // Latched transaction
  logic [2:0]  op_q;
  logic [15:0] e_q, e_d;
  logic [7:0]  lim_q;

  // Drain count
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [8:0]       n_fl;
  logic [CNT_W-1:0] n_w;

  // Seconds remainder
  logic [31:0]        tl_m1;
  logic [PROD_W-1:0]  prod, prod_q;
  logic [QUO_W-1:0]   quo;
  logic [31:0]        quo_k;
  logic [9:0]         rem_q;

  // Phase-end values
  logic [1:0]  fin_phase;
  logic [1:0]  fin_sess;
  logic [31:0] fin_len;
  logic        do_finish;

  // Output register
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_free;

  // Zero written means 1 ms
  assign cfg_val = (cfg_data_i == 32'd0) ? 32'd1 : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q  <= WORK_RST;
      short_q <= SHORT_RST;
      long_q  <= LONG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORK:  work_q  <= cfg_val;
        CFG_SHORT: short_q <= cfg_val;
        CFG_LONG:  long_q  <= cfg_val;
        default: ;
      endcase
    end
  end

  // Next phase, session count and length at a phase end
  always_comb begin
    fin_sess = sess_q;
    if (phase_q == PH_WORK) begin
      if (sess_q < SESS_MAX) begin
        fin_sess  = sess_q + 2'd1;
        fin_phase = PH_SHORT;
      end else begin
        fin_sess  = SESS_MAX;
        fin_phase = PH_LONG;
      end
    end else begin
      if (phase_q == PH_LONG) fin_sess = 2'd0;
      fin_phase = PH_WORK;
    end
    case (fin_phase)
      PH_SHORT: fin_len = short_q;
      PH_LONG:  fin_len = long_q;
      default:  fin_len = work_q;
    endcase
  end

  // Queue write address: head + fill, wrapped; equals head when full
  assign wr_sum  = {1'b0, head_q} + (PTR_W+1)'(fill_q);
  assign wr_addr = (wr_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                   PTR_W'(wr_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(wr_sum);
  assign entry   = queue_q[head_q];

  // Drain count: min(fill, limit, MAX_RESULTS)
  always_comb begin
    n_fl = (9'(fill_q) < {1'b0, lim_q}) ? 9'(fill_q) : {1'b0, lim_q};
    if (n_fl > 9'(MAX_RESULTS)) n_fl = 9'(MAX_RESULTS);
    n_w = CNT_W'(n_fl);
  end

  // Reciprocal multiply for (time_left - 1) / 1000, then the remainder
  assign tl_m1 = tl_q - 32'd1;
  assign prod  = PROD_W'(tl_m1) * PROD_W'(DIV_MUL);
  assign quo   = prod_q[PROD_W-1:DIV_SHIFT];
  assign quo_k = 32'(quo) * 32'(MS_PER_SEC);

  // State update
  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_q;
    tl_d      = tl_q;
    len_d     = len_q;
    sess_d    = sess_q;
    gen_d     = gen_q;
    trc_d     = trc_q;
    fill_d    = fill_q;
    head_d    = head_q;
    e_d       = e_q;
    cnt_d     = cnt_q;
    do_finish = 1'b0;
    rec       = 1'b0;

    if (cmd_i.load) e_d = in_data_i.elapsed_ms;

    if (cmd_i.apply) begin
      case (op_q)
        OP_START: begin
          if (mode_q == RS_IDLE) begin
            mode_d = RS_RUN;
            gen_d  = gen_q + 32'd1;
          end
        end
        OP_PAUSE: begin
          if (mode_q == RS_RUN) begin
            mode_d = RS_PAUSE;
            gen_d  = gen_q + 32'd1;
          end
        end
        OP_RESUME: begin
          if (mode_q == RS_PAUSE) begin
            mode_d = RS_RUN;
            gen_d  = gen_q + 32'd1;
          end
        end
        OP_TOGGLE: begin
          mode_d = (mode_q == RS_RUN) ? RS_PAUSE : RS_RUN;
          gen_d  = gen_q + 32'd1;
        end
        OP_RESET: begin
          mode_d  = RS_IDLE;
          phase_d = PH_WORK;
          len_d   = work_q;
          tl_d    = work_q;
          sess_d  = 2'd0;
          fill_d  = '0;
          gen_d   = gen_q + 32'd1;
        end
        OP_SKIP: do_finish = 1'b1;
        default: ;
      endcase
    end

    // Tick runs past the phase end: carry the surplus on
    if (cmd_i.tick_finish) begin
      e_d       = e_q - tl_q[15:0];
      do_finish = 1'b1;
    end

    if (do_finish) begin
      phase_d = fin_phase;
      len_d   = fin_len;
      tl_d    = fin_len;
      mode_d  = RS_RUN;
      sess_d  = fin_sess;
      gen_d   = gen_q + 32'd1;
      trc_d   = trc_q + 32'd1;
      rec     = 1'b1;
      if (fill_q == FILL_W'(QUEUE_DEPTH)) begin
        head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
      end else begin
        fill_d = fill_q + FILL_W'(1);
      end
    end

    // Tick inside the phase: bump if the shown seconds change
    if (cmd_i.tick_sub) begin
      tl_d = tl_q - {16'd0, e_q};
      if (e_q > {6'd0, rem_q}) gen_d = gen_q + 32'd1;
    end

    if (cmd_i.drain_start) begin
      cnt_d  = n_w;
      fill_d = fill_q - FILL_W'(n_w);
    end

    if (cmd_i.pop) begin
      head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WORK;
      mode_q  <= RS_IDLE;
      tl_q    <= WORK_RST;
      len_q   <= WORK_RST;
      sess_q  <= 2'd0;
      gen_q   <= '0;
      trc_q   <= '0;
      fill_q  <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      tl_q    <= tl_d;
      len_q   <= len_d;
      sess_q  <= sess_d;
      gen_q   <= gen_d;
      trc_q   <= trc_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload registers: transaction fields, product, remainder, queue
  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    prod_q <= prod;
    if (cmd_i.load) begin
      op_q  <= in_data_i.operation;
      lim_q <= in_data_i.take_limit;
    end
    if (cmd_i.rem_calc) rem_q <= 10'(tl_m1 - quo_k);
    if (rec) queue_q[wr_addr] <= {fin_phase, phase_q};
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit || cmd_i.pop) begin
      out_q.phase            <= phase_q;
      out_q.run_state        <= mode_q;
      out_q.remaining_ms     <= tl_q;
      out_q.duration_ms      <= len_q;
      out_q.sessions_done    <= sess_q;
      out_q.change_count     <= gen_q;
      out_q.transition_count <= trc_q;
      out_q.pending          <= 4'(fill_q);
      out_q.transition_valid <= cmd_i.pop;
      out_q.from_phase       <= cmd_i.pop ? entry[1:0] : 2'd0;
      out_q.to_phase         <= cmd_i.pop ? entry[3:2] : 2'd0;
      out_q.last             <= cmd_i.emit || (cnt_q == CNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller
  assign sts_o.op         = op_q;
  assign sts_o.running    = (mode_q == RS_RUN);
  assign sts_o.e_zero     = (e_q == 16'd0);
  assign sts_o.tl_gt_e    = (tl_q > {16'd0, e_q});
  assign sts_o.drain_none = (n_w == '0);
  assign sts_o.cnt_last   = (cnt_q == CNT_W'(1));
  assign sts_o.out_free   = out_free;

endmodule

`default_nettype wire

// ===== hdl/ipt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipt_ctrl: sequencing state machine for the interval phase timer
// Accepts one transaction at a time, steps the datapath through command
// execution, the tick loop and queue drain, and issues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_ctrl import ipt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output ipt_cmd_t      cmd_o,
  input  wire ipt_sts_t sts_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_SUB   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.op == OP_TICK) begin
          state_d = S_TICK;
        end else if (sts_i.op == OP_DRAIN) begin
          if (sts_i.drain_none) begin
            state_d = S_EMIT;
          end else begin
            cmd_o.drain_start = 1'b1;
            state_d           = S_DRAIN;
          end
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = S_EMIT;
        end
      end
      // One phase end per cycle until the tick lands inside a phase
      S_TICK: begin
        if (!sts_i.running || sts_i.e_zero) begin
          state_d = S_EMIT;
        end else if (sts_i.tl_gt_e) begin
          state_d = S_REM;
        end else begin
          cmd_o.tick_finish = 1'b1;
        end
      end
      S_REM: begin
        cmd_o.rem_calc = 1'b1;
        state_d        = S_SUB;
      end
      S_SUB: begin
        cmd_o.tick_sub = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (sts_i.cnt_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/interval_phase_timer.sv =====
// ----------------------------------------------------------------------------
// interval_phase_timer: three-phase work/break interval timer
// Top level: controller plus datapath, valid/stall channels and a plain
// configuration write port.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A command other than tick or
// drain is accepted, executed and issued. A tick that stays inside the
// current phase is accepted, executed and compared, then forms the remainder
// of the shown seconds through a registered reciprocal multiply by 1/1000,
// subtracts and issues; when the timer is not running or the elapsed time is
// zero it is issued straight after the compare. The phase-end loop retires
// one phase end per cycle, for every phase end the tick crosses. A drain is
// accepted, takes its count off the queue and hands out its transitions one
// by one, or issues a single result when it hands out none. Results wait in
// a single output register; an output stall holds the issuing cycle, and the
// next transaction is taken as soon as the previous result is loaded there.
// Configuration writes take effect at the next phase entry or reset command.
`default_nettype none

module interval_phase_timer import ipt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  ipt_cmd_t cmd;
  ipt_sts_t sts;

  // Sequencer
  ipt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // State, queue and output register
  ipt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
